FILE: rtl/cbvd_pkg.sv
// Shared types, constants and codes for the crop box voxel downsampler.
package cbvd_pkg;

  localparam int GRID_X = 64;
  localparam int GRID_Y = 64;
  localparam int GRID_Z = 64;
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int CELL_W = $clog2(CELLS);
  localparam int ROW_BITS = 6;
  localparam int ROW_W = 1 << ROW_BITS;
  localparam int ROWS = (CELLS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = $clog2(ROWS);

  localparam int DVD_W = 17;
  localparam int DVS_W = 12;
  localparam int DCNT_W = $clog2(DVD_W);

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_END = 2'd2;

  localparam logic [2:0] REG_LEAF = 3'd0;
  localparam logic [2:0] REG_STEP = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_Z = 3'd3;
  localparam logic [2:0] REG_MIN_X = 3'd4;
  localparam logic [2:0] REG_MAX_X = 3'd5;
  localparam logic [2:0] REG_MIN_Y = 3'd6;
  localparam logic [2:0] REG_MAX_Y = 3'd7;

  localparam logic [1:0] AXIS_Z = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_X = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [11:0] column;
    logic [11:0] row;
    logic coords_finite;
    logic signed [15:0] x_mm;
    logic signed [15:0] y_mm;
    logic signed [15:0] z_mm;
  } in_t;

  typedef struct packed {
    logic kind;
    logic signed [15:0] out_x_mm;
    logic signed [15:0] out_y_mm;
    logic signed [15:0] out_z_mm;
    logic grid_overflow;
    logic [23:0] lattice_count;
    logic [23:0] valid_count;
    logic [23:0] boxed_count;
    logic [23:0] kept_count;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODC,
    ST_MODR,
    ST_DIV,
    ST_MRD,
    ST_MCHK,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/cbvd_div.sv
// Restoring divider that produces one quotient bit per cycle.
module cbvd_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [cbvd_pkg::DVD_W-1:0] dividend,
  input  logic [cbvd_pkg::DVS_W-1:0] divisor,
  output logic done,
  output logic [cbvd_pkg::DVD_W-1:0] quotient,
  output logic [cbvd_pkg::DVS_W-1:0] remainder
);
  import cbvd_pkg::*;

  logic busy;
  logic [DCNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0] sh;
  logic take;

  assign sh = {remainder, quotient[DVD_W-1]};
  assign take = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt <= DCNT_W'(DVD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DVD_W-2:0], take};
      remainder <= take ? DVS_W'(sh - {1'b0, dvs}) : sh[DVS_W-1:0];
    end
  end

endmodule

FILE: rtl/crop_box_voxel_downsampler.sv
// Top level of the crop box voxel downsampler with its sequencer and visited map.
// A pixel takes one or two divider runs for the lattice test, then up to three more
// runs for the voxel index and a read and check of the visited map, all on one shared
// bit-serial divider, plus any output stall.
// An end beat goes straight to the output stage; a start beat clears the map's 4096 rows.
// Reset (rst, synchronous) loads register defaults and runs the same map clear.
module crop_box_voxel_downsampler (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cbvd_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cbvd_pkg::out_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import cbvd_pkg::*;

  localparam int AX_W = $clog2(GRID_X > GRID_Y ? (GRID_X > GRID_Z ? GRID_X : GRID_Z)
                                               : (GRID_Y > GRID_Z ? GRID_Y : GRID_Z));

  state_t state, state_next;

  logic [11:0] leaf_size_mm;
  logic [6:0] step_size;
  logic signed [15:0] min_depth_mm, max_depth_mm, min_x_mm, max_x_mm, min_y_mm, max_y_mm;
  logic signed [15:0] org_x, org_y, org_z;
  logic [23:0] sampled_total, finite_total, cropped_total, kept_total;

  in_t cur;
  out_t out_data_next;
  logic ovf;
  logic [1:0] axis;
  logic [CELL_W-1:0] acc;
  logic [ROW_AW-1:0] clr_addr;
  logic dv_started;

  logic dv_start, dv_done;
  logic [DVD_W-1:0] dv_dividend, dv_quo;
  logic [DVS_W-1:0] dv_divisor, dv_rem;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_data;
  logic mem_we;
  logic [ROW_AW-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [ROW_AW-1:0] row_addr;
  logic [ROW_W-1:0] bit_mask;
  logic hit;

  logic accept_in, out_free, emit_load;
  logic inc_sampled, inc_finite, inc_cropped;
  logic crop_ok, axis_neg, q_big, step_ok;
  logic signed [16:0] p_sel, o_sel, diff;
  logic [DVD_W-1:0] dim_sel;
  logic [6:0] step_eff;

  assign step_eff = (step_size == '0) ? 7'd1 : step_size;
  assign out_free = !out_valid || out_ready;
  assign accept_in = in_valid && in_ready;
  assign crop_ok = (cur.z_mm >= min_depth_mm) && (cur.z_mm <= max_depth_mm) &&
                   (cur.x_mm >= min_x_mm) && (cur.x_mm <= max_x_mm) &&
                   (cur.y_mm >= min_y_mm) && (cur.y_mm <= max_y_mm);
  assign step_ok = (dv_rem == '0);

  always_comb begin
    p_sel = 17'(cur.x_mm);
    o_sel = 17'(org_x);
    dim_sel = DVD_W'(GRID_X);
    case (axis)
      AXIS_Z: begin
        p_sel = 17'(cur.z_mm);
        o_sel = 17'(org_z);
        dim_sel = DVD_W'(GRID_Z);
      end
      AXIS_Y: begin
        p_sel = 17'(cur.y_mm);
        o_sel = 17'(org_y);
        dim_sel = DVD_W'(GRID_Y);
      end
      default: ;
    endcase
  end

  assign diff = p_sel - o_sel;
  assign axis_neg = diff[16];
  assign q_big = dv_quo >= dim_sel;
  assign row_addr = acc[CELL_W-1:ROW_BITS];
  assign bit_mask = ROW_W'(1) << acc[ROW_BITS-1:0];
  assign hit = |(rd_data & bit_mask);

  always_comb begin
    dv_dividend = DVD_W'(diff);
    dv_divisor = leaf_size_mm;
    if (state == ST_MODC) begin
      dv_dividend = DVD_W'(cur.column);
      dv_divisor = DVS_W'(step_eff);
    end else if (state == ST_MODR) begin
      dv_dividend = DVD_W'(cur.row);
      dv_divisor = DVS_W'(step_eff);
    end
  end

  cbvd_div u_div (
    .clk(clk),
    .rst(rst),
    .start(dv_start),
    .dividend(dv_dividend),
    .divisor(dv_divisor),
    .done(dv_done),
    .quotient(dv_quo),
    .remainder(dv_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ROW_AW'(ROWS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept_in) begin
          case (in_data.action)
            ACT_START: state_next = ST_CLEAR;
            ACT_PIXEL: state_next = ST_MODC;
            ACT_END: state_next = ST_EMIT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_MODC: if (dv_done) state_next = step_ok ? ST_MODR : ST_IDLE;
      ST_MODR: begin
        if (dv_done) begin
          if (!step_ok || !cur.coords_finite || !crop_ok) state_next = ST_IDLE;
          else if (leaf_size_mm == '0) state_next = ST_EMIT;
          else state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!dv_started && axis_neg) state_next = ST_EMIT;
        else if (dv_done) begin
          if (q_big) state_next = ST_EMIT;
          else if (axis == AXIS_X) state_next = ST_MRD;
        end
      end
      ST_MRD: state_next = ST_MCHK;
      ST_MCHK: state_next = hit ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    dv_start = 1'b0;
    inc_sampled = 1'b0;
    inc_finite = 1'b0;
    inc_cropped = 1'b0;
    emit_load = 1'b0;
    mem_we = 1'b0;
    mem_waddr = row_addr;
    mem_wdata = rd_data | bit_mask;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_MODC: dv_start = !dv_started;
      ST_MODR: begin
        dv_start = !dv_started;
        inc_sampled = dv_done && step_ok;
        inc_finite = inc_sampled && cur.coords_finite;
        inc_cropped = inc_finite && crop_ok;
      end
      ST_DIV: dv_start = !dv_started && !axis_neg;
      ST_MCHK: mem_we = !hit;
      ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_data_next = '0;
    if (cur.action == ACT_END) begin
      out_data_next.kind = 1'b1;
      out_data_next.lattice_count = sampled_total;
      out_data_next.valid_count = finite_total;
      out_data_next.boxed_count = cropped_total;
      out_data_next.kept_count = kept_total;
    end else begin
      out_data_next.out_x_mm = cur.x_mm;
      out_data_next.out_y_mm = cur.y_mm;
      out_data_next.out_z_mm = cur.z_mm;
      out_data_next.grid_overflow = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      dv_started <= 1'b0;
      out_valid <= 1'b0;
      leaf_size_mm <= 12'd80;
      step_size <= 7'd4;
      min_depth_mm <= 16'sd300;
      max_depth_mm <= 16'sd3000;
      min_x_mm <= -16'sd2000;
      max_x_mm <= 16'sd2000;
      min_y_mm <= -16'sd1500;
      max_y_mm <= 16'sd1500;
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      sampled_total <= '0;
      finite_total <= '0;
      cropped_total <= '0;
      kept_total <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEAF: leaf_size_mm <= cfg_data[11:0];
          REG_STEP: step_size <= cfg_data[6:0];
          REG_MIN_Z: min_depth_mm <= cfg_data;
          REG_MAX_Z: max_depth_mm <= cfg_data;
          REG_MIN_X: min_x_mm <= cfg_data;
          REG_MAX_X: max_x_mm <= cfg_data;
          REG_MIN_Y: min_y_mm <= cfg_data;
          REG_MAX_Y: max_y_mm <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (dv_start) dv_started <= 1'b1;
      else if (dv_done) dv_started <= 1'b0;
      if (accept_in && in_data.action == ACT_START) begin
        clr_addr <= '0;
        org_x <= min_x_mm;
        org_y <= min_y_mm;
        org_z <= min_depth_mm;
        sampled_total <= '0;
        finite_total <= '0;
        cropped_total <= '0;
        kept_total <= '0;
      end
      if (inc_sampled && sampled_total != CNT_MAX) sampled_total <= sampled_total + 1'b1;
      if (inc_finite && finite_total != CNT_MAX) finite_total <= finite_total + 1'b1;
      if (inc_cropped && cropped_total != CNT_MAX) cropped_total <= cropped_total + 1'b1;
      if (emit_load && cur.action != ACT_END && kept_total != CNT_MAX) begin
        kept_total <= kept_total + 1'b1;
      end
      if (emit_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cur <= in_data;
      ovf <= 1'b0;
      axis <= AXIS_Z;
    end
    if (state == ST_DIV) begin
      if (!dv_started && axis_neg) ovf <= 1'b1;
      else if (dv_done) begin
        if (q_big) ovf <= 1'b1;
        axis <= axis + 1'b1;
        unique case (axis)
          AXIS_Z: acc <= CELL_W'(dv_quo[AX_W-1:0]);
          AXIS_Y: acc <= CELL_W'(dv_quo[AX_W-1:0]) + CELL_W'(GRID_Y) * acc;
          default: acc <= CELL_W'(dv_quo[AX_W-1:0]) + CELL_W'(GRID_X) * acc;
        endcase
      end
    end
    if (emit_load) out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[row_addr];
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (accept_in && in_data.action == ACT_START) |=> (state == ST_CLEAR && clr_addr == '0))
    else $error("start beat did not begin a map clear");

  a_kept_le_cropped: assert property (@(posedge clk) disable iff (rst)
    kept_total <= cropped_total)
    else $error("kept count exceeds cropped count");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == ST_MODC || state == ST_MODR || state == ST_DIV))
    else $error("divider finished outside a divide step");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !out_free) |=> (state == ST_EMIT && out_valid))
    else $error("result lost while output register was full");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the crop box voxel downsampler.
`timescale 1ns / 100ps

module testbench;
  import cbvd_pkg::*;

  class point_scoreboard;
    int leaf, step, min_z, max_z, min_x, max_x, min_y, max_y;
    int origin[3];
    bit visited[int];
    logic [23:0] n_sampled, n_finite, n_cropped, n_kept;
    out_t expected_results[$];
    int errors, frames, points, overflows;

    function new();
      leaf = 80; step = 4; min_z = 300; max_z = 3000;
      min_x = -2000; max_x = 2000; min_y = -1500; max_y = 1500;
      origin = '{0, 0, 0};
      n_sampled = 0; n_finite = 0; n_cropped = 0; n_kept = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_LEAF: leaf = int'(val[11:0]);
        REG_STEP: step = int'(val[6:0]);
        REG_MIN_Z: min_z = int'($signed(val));
        REG_MAX_Z: max_z = int'($signed(val));
        REG_MIN_X: min_x = int'($signed(val));
        REG_MAX_X: max_x = int'($signed(val));
        REG_MIN_Y: min_y = int'($signed(val));
        REG_MAX_Y: max_y = int'($signed(val));
        default: ;
      endcase
    endfunction

    function void accept_beat(in_t b);
      out_t r;
      int stp, d, q, vox_idx;
      int p[3];
      int dim[3];
      bit ovf;
      r = '0;
      ovf = 0;
      vox_idx = 0;
      dim = '{GRID_X, GRID_Y, GRID_Z};
      case (b.action)
        ACT_START: begin
          visited.delete();
          n_sampled = 0; n_finite = 0; n_cropped = 0; n_kept = 0;
          origin = '{min_x, min_y, min_z};
        end
        ACT_END: begin
          r.kind = 1'b1;
          r.lattice_count = n_sampled;
          r.valid_count = n_finite;
          r.boxed_count = n_cropped;
          r.kept_count = n_kept;
          expected_results = {expected_results, r};
          frames++;
        end
        ACT_PIXEL: begin
          stp = (step == 0) ? 1 : step;
          if ((int'(b.column) % stp) != 0 || (int'(b.row) % stp) != 0) return;
          if (n_sampled != CNT_MAX) n_sampled++;
          if (!b.coords_finite) return;
          if (n_finite != CNT_MAX) n_finite++;
          p[0] = int'(b.x_mm); p[1] = int'(b.y_mm); p[2] = int'(b.z_mm);
          if (p[2] < min_z || p[2] > max_z || p[0] < min_x || p[0] > max_x ||
              p[1] < min_y || p[1] > max_y) return;
          if (n_cropped != CNT_MAX) n_cropped++;
          if (leaf != 0) begin
            for (int a = 2; a >= 0; a--) begin
              d = p[a] - origin[a];
              q = (d < 0) ? 0 : d / leaf;
              if (d < 0 || q >= dim[a]) ovf = 1;
              vox_idx = vox_idx * dim[a] + q;
            end
            if (!ovf) begin
              if (visited.exists(vox_idx)) return;
              visited[vox_idx] = 1;
            end
          end
          if (n_kept != CNT_MAX) n_kept++;
          r.out_x_mm = b.x_mm;
          r.out_y_mm = b.y_mm;
          r.out_z_mm = b.z_mm;
          r.grid_overflow = ovf;
          expected_results = {expected_results, r};
          points++;
          if (ovf) overflows++;
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [23:0] e, logic [23:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (expected_results.size() == 0) begin
        $error("Unexpected result beat: %0h", a);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      cmp("kind", 24'(e.kind), 24'(a.kind));
      cmp("out_x_mm", 24'(e.out_x_mm), 24'(a.out_x_mm));
      cmp("out_y_mm", 24'(e.out_y_mm), 24'(a.out_y_mm));
      cmp("out_z_mm", 24'(e.out_z_mm), 24'(a.out_z_mm));
      cmp("grid_overflow", 24'(e.grid_overflow), 24'(a.grid_overflow));
      cmp("lattice_count", e.lattice_count, a.lattice_count);
      cmp("valid_count", e.valid_count, a.valid_count);
      cmp("boxed_count", e.boxed_count, a.boxed_count);
      cmp("kept_count", e.kept_count, a.kept_count);
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  point_scoreboard sb = new();
  bit hold_req, calm;
  int quiet_cycles;

  crop_box_voxel_downsampler u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 26);
        @(posedge clk);
        if (out_valid && out_ready) sb.check_result(out_data);
      end
    end
  end

  task automatic send_beat(in_t b);
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.accept_beat(b);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
  endtask

  function automatic in_t mk(logic [1:0] act, int col, int row, int fin, int x, int y, int z);
    in_t b;
    b.action = act;
    b.column = 12'(col);
    b.row = 12'(row);
    b.coords_finite = fin[0];
    b.x_mm = 16'(x);
    b.y_mm = 16'(y);
    b.z_mm = 16'(z);
    return b;
  endfunction

  function automatic int near(int lo, int hi);
    int span;
    span = (sb.leaf == 0) ? 300 : 5 * sb.leaf;
    if (hi < lo) return $urandom_range(0, 65535) - 32768;
    if (hi - lo < span) span = hi - lo;
    return lo + $urandom_range(0, span);
  endfunction

  function automatic in_t random_pixel();
    int stp, col, row;
    in_t b;
    stp = (sb.step == 0) ? 1 : sb.step;
    col = stp * $urandom_range(0, 4095 / stp);
    row = stp * $urandom_range(0, 4095 / stp);
    if ($urandom_range(0, 99) < 15) col = $urandom_range(0, 4095);
    if ($urandom_range(0, 99) < 15) row = $urandom_range(0, 4095);
    if ($urandom_range(0, 99) < 70)
      b = mk(ACT_PIXEL, col, row, int'($urandom_range(0, 99) < 92), near(sb.min_x, sb.max_x),
             near(sb.min_y, sb.max_y), near(sb.min_z, sb.max_z));
    else
      b = mk(ACT_PIXEL, col, row, $urandom_range(0, 1), $urandom, $urandom, $urandom);
    if ($urandom_range(0, 99) < 2) b.action = 2'd3;
    return b;
  endfunction

  int cfgs[7][8] = '{
    '{80, 4, 300, 3000, -2000, 2000, -1500, 1500},
    '{0, 1, -32768, 32767, -32768, 32767, -32768, 32767},
    '{4095, 64, -32768, 32767, -32768, 32767, -32768, 32767},
    '{1, 2, -10, 70, -10, 70, -10, 70},
    '{16, 0, -500, 500, -500, 500, -500, 500},
    '{10, 3, 100, -100, 100, -100, 100, -100},
    '{1000, 5, 0, 32767, -32768, 32767, -32768, 32767}
  };

  initial begin
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    calm = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Points before the first frame start see a zero origin.
    send_beat(mk(ACT_PIXEL, 0, 0, 1, -2000, 0, 500));
    send_beat(mk(ACT_PIXEL, 4, 8, 1, 100, 100, 400));
    send_beat(mk(ACT_END, 0, 0, 0, 0, 0, 0));
    send_beat(mk(2'd3, 4095, 4095, 1, -1, -1, -1));
    send_beat(mk(ACT_START, 4095, 4095, 1, 32767, -32768, 32767));
    send_beat(mk(ACT_PIXEL, 0, 0, 1, -2000, -1500, 300));
    send_beat(mk(ACT_PIXEL, 4, 4, 1, -1990, -1490, 310));
    send_beat(mk(ACT_PIXEL, 8, 4, 1, 2000, 1500, 3000));
    send_beat(mk(ACT_PIXEL, 4092, 4092, 1, 0, 0, 1000));
    send_beat(mk(ACT_PIXEL, 4095, 4092, 1, 0, 0, 1000));
    send_beat(mk(ACT_PIXEL, 4092, 4095, 1, 0, 0, 1000));
    send_beat(mk(ACT_PIXEL, 12, 12, 0, 32767, -32768, -32768));
    send_beat(mk(ACT_PIXEL, 12, 16, 1, 0, 0, 299));
    send_beat(mk(ACT_PIXEL, 12, 16, 1, 0, 0, 3001));
    send_beat(mk(ACT_PIXEL, 12, 16, 1, -2001, 0, 1000));
    send_beat(mk(ACT_PIXEL, 12, 16, 1, 0, 1501, 1000));
    send_beat(mk(ACT_PIXEL, 16, 16, 1, 1999, 1499, 2999));
    send_beat(mk(ACT_PIXEL, 16, 20, 1, 32767, 32767, 32767));
    send_beat(mk(ACT_PIXEL, 20, 20, 1, -32768, -32768, -32768));
    send_beat(mk(ACT_END, 0, 0, 0, 0, 0, 0));
    drain_block();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        for (int r = 0; r < 8; r++) write_reg(3'(r), 16'(cfgs[ph][r]));
        cfg_we <= 1'b0;
      end
      calm = (ph == 2);
      n = 0;
      while (n < 220) begin
        if (ph == 0 || $urandom_range(0, 3) != 0 || n > 0)
          send_beat(mk(ACT_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        for (int k = $urandom_range(20, 80); k > 0; k--) begin
          if (ph == 3 && n == 100) hold_req = 1;
          send_beat(random_pixel());
          n++;
        end
        send_beat(mk(ACT_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      end
      drain_block();
    end

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d frame reports and %0d kept points, %0d of them outside the grid,",
             sb.frames, sb.points, sb.overflows);
    $display("over seven register settings including disabled dedup and an inverted box.");
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
